// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed: label");

// Antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: label");

`endif

// ===== rtl/core/pab_pkg.sv =====
// Package for the priority alarm beeper: register map, resets, shared types
package pab_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int IN_TDATA_W = 72;
	localparam int OUT_TDATA_W = 8;

	typedef enum logic [2:0] {
		REG_PRESENT  = 3'd0,
		REG_SOUND    = 3'd1,
		REG_SOIL_TH  = 3'd2,
		REG_BATT_TH  = 3'd3,
		REG_INTERVAL = 3'd4,
		REG_ON       = 3'd5,
		REG_OFF      = 3'd6
	} reg_idx_t;

	localparam logic        RST_PRESENT  = 1'b1;
	localparam logic        RST_SOUND    = 1'b1;
	localparam logic [6:0]  RST_SOIL_TH  = 7'd30;
	localparam logic [15:0] RST_BATT_TH  = 16'd3300;
	localparam logic [31:0] RST_INTERVAL = 32'd10000;
	localparam logic [15:0] RST_ON       = 16'd300;
	localparam logic [15:0] RST_OFF      = 16'd400;

	localparam logic [15:0] BATT_ABSENT_MV = 16'd100;

	localparam logic [1:0] BURST_BATT  = 2'd3;
	localparam logic [1:0] BURST_WATER = 2'd2;
	localparam logic [1:0] BURST_SOIL  = 2'd1;

	typedef struct packed {
		logic water;
		logic battery;
		logic soil;
	} cause_t;

endpackage

// ===== rtl/core/pab_cause.sv =====
// Alarm cause detection from one sensor beat
module pab_cause (
	input  logic signed [15:0] water_level,
	input  logic [15:0]        battery_mv,
	input  logic signed [7:0]  soil_moisture,
	input  logic [6:0]         soil_threshold_pct,
	input  logic [15:0]        battery_threshold_mv,
	output pab_pkg::cause_t    cause
);
	import pab_pkg::*;

	always_comb begin
		cause.water   = (water_level <= 16'sd0);
		cause.battery = (battery_mv > BATT_ABSENT_MV) && (battery_mv < battery_threshold_mv);
		cause.soil    = !soil_moisture[7] && (soil_moisture[6:0] < soil_threshold_pct);
	end

endmodule

// ===== rtl/core/priority_alarm_beeper.sv =====
// Top level of the priority alarm beeper
// One sensor beat in, one status beat out. A beat is taken into an input
// register, evaluated against the held alarm and burst timer state, and the
// status lands in an output register; while the sink takes each status, a new
// beat can be taken every clock, so the block sustains one beat per cycle. The
// output register holds a status while the sink stalls; the input register keeps
// accepting as long as its beat can move on. Configuration is written through
// the APB port at byte address 4*index; the user must change it only while no
// beat is in flight, and the block itself does not enforce this.
module priority_alarm_beeper #(
	parameter int TIME_WIDTH = pab_pkg::TIME_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// APB configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pab_pkg::ADDR_W-1:0]       paddr,
	input  logic [pab_pkg::DATA_W-1:0]       pwdata,
	output logic [pab_pkg::DATA_W-1:0]       prdata,
	output logic                             pready,
	// sensor beats
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// now_ms[31:0], water_level[47:32], battery_mv[63:48], soil_moisture[71:64]
	input  logic [pab_pkg::IN_TDATA_W-1:0]   s_tdata,
	// status beats
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// buzzer_drive[0], alarm_active[1], alarm_changed[2], water_cause[3],
	// battery_cause[4], soil_cause[5], zero[7:6]
	output logic [pab_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import pab_pkg::*;

	localparam int CMP_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

	// configuration registers
	logic        present_q;
	logic        sound_q;
	logic [6:0]  soil_th_q;
	logic [15:0] batt_th_q;
	logic [31:0] interval_q;
	logic [15:0] on_q;
	logic [15:0] off_q;

	reg_idx_t cfg_idx;
	logic     cfg_wr;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q  <= RST_PRESENT;
			sound_q    <= RST_SOUND;
			soil_th_q  <= RST_SOIL_TH;
			batt_th_q  <= RST_BATT_TH;
			interval_q <= RST_INTERVAL;
			on_q       <= RST_ON;
			off_q      <= RST_OFF;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_PRESENT:  present_q  <= pwdata[0];
				REG_SOUND:    sound_q    <= pwdata[0];
				REG_SOIL_TH:  soil_th_q  <= pwdata[6:0];
				REG_BATT_TH:  batt_th_q  <= pwdata[15:0];
				REG_INTERVAL: interval_q <= pwdata[31:0];
				REG_ON:       on_q       <= pwdata[15:0];
				REG_OFF:      off_q      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_PRESENT:  prdata = {31'd0, present_q};
			REG_SOUND:    prdata = {31'd0, sound_q};
			REG_SOIL_TH:  prdata = {25'd0, soil_th_q};
			REG_BATT_TH:  prdata = {16'd0, batt_th_q};
			REG_INTERVAL: prdata = interval_q;
			REG_ON:       prdata = {16'd0, on_q};
			REG_OFF:      prdata = {16'd0, off_q};
			default:      prdata = '0;
		endcase
	end

	// input register
	logic                  valid_s1;
	logic [31:0]           now_s1;
	logic signed [15:0]    water_s1;
	logic [15:0]           batt_s1;
	logic signed [7:0]     soil_s1;
	logic                  out_free;
	logic                  advance;

	assign out_free = !m_tvalid || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			now_s1   <= s_tdata[31:0];
			water_s1 <= s_tdata[47:32];
			batt_s1  <= s_tdata[63:48];
			soil_s1  <= s_tdata[71:64];
		end
	end

	// alarm and burst state
	logic                  active_q;
	cause_t                cause_q;
	logic [TIME_WIDTH-1:0] cycle_start_q;
	logic [TIME_WIDTH-1:0] phase_start_q;
	logic [1:0]            beeps_q;
	logic [1:0]            burst_len_q;
	logic                  buzzer_q;

	cause_t cause_c;

	pab_cause u_cause (
		.water_level          (water_s1),
		.battery_mv           (batt_s1),
		.soil_moisture        (soil_s1),
		.soil_threshold_pct   (soil_th_q),
		.battery_threshold_mv (batt_th_q),
		.cause                (cause_c)
	);

	logic [CMP_W-1:0]      now_ext;
	logic [TIME_WIDTH-1:0] now_t;
	logic [CMP_W-1:0]      interval_ext;
	logic [CMP_W-1:0]      onset_cs_ext;
	logic                  active_c;
	logic                  run;
	logic [TIME_WIDTH-1:0] cs_eff;
	logic [TIME_WIDTH-1:0] cyc_elapsed;
	logic                  burst_start;
	logic [1:0]            blen_c;
	logic [1:0]            beeps_eff;
	logic                  buzzer_eff;
	logic [TIME_WIDTH-1:0] ps_eff;
	logic [TIME_WIDTH-1:0] cs_next;
	logic [TIME_WIDTH-1:0] ph_elapsed;
	logic [CMP_W-1:0]      ph_elapsed_ext;
	logic [TIME_WIDTH-1:0] ps_next;
	logic [1:0]            beeps_next;
	logic                  buzzer_next;

	always_comb begin
		now_ext      = CMP_W'(now_s1);
		now_t        = now_ext[TIME_WIDTH-1:0];
		interval_ext = CMP_W'(interval_q);
		onset_cs_ext = now_ext - interval_ext - CMP_W'(1);
		active_c     = cause_c.water || cause_c.battery || cause_c.soil;
		run          = active_c && sound_q;

		cs_eff      = !active_q ? onset_cs_ext[TIME_WIDTH-1:0] : cycle_start_q;
		cyc_elapsed = now_t - cs_eff;
		burst_start = (CMP_W'(cyc_elapsed) >= interval_ext) && (beeps_q == 2'd0);

		if (cause_c.battery) begin
			blen_c = BURST_BATT;
		end else if (cause_c.water) begin
			blen_c = BURST_WATER;
		end else begin
			blen_c = BURST_SOIL;
		end

		beeps_eff  = burst_start ? blen_c : beeps_q;
		buzzer_eff = burst_start ? 1'b0 : buzzer_q;
		ps_eff     = burst_start ? now_t : phase_start_q;
		cs_next    = burst_start ? now_t : cs_eff;

		ph_elapsed     = now_t - ps_eff;
		ph_elapsed_ext = CMP_W'(ph_elapsed);
		ps_next        = ps_eff;
		beeps_next     = beeps_eff;
		buzzer_next    = buzzer_eff;
		if (beeps_eff != 2'd0) begin
			if (!buzzer_eff && ph_elapsed_ext >= CMP_W'(off_q)) begin
				buzzer_next = 1'b1;
				ps_next     = now_t;
			end else if (buzzer_eff && ph_elapsed_ext >= CMP_W'(on_q)) begin
				buzzer_next = 1'b0;
				beeps_next  = beeps_eff - 2'd1;
				ps_next     = now_t;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			cause_q       <= '0;
			cycle_start_q <= '0;
			phase_start_q <= '0;
			beeps_q       <= '0;
			burst_len_q   <= '0;
			buzzer_q      <= 1'b0;
			m_tvalid      <= 1'b0;
			m_tdata       <= '0;
		end else begin
			if (out_free) begin
				m_tvalid <= valid_s1;
			end
			if (advance) begin
				if (!present_q) begin
					m_tdata <= {2'b00, cause_q.soil, cause_q.battery, cause_q.water,
						1'b0, active_q, buzzer_q};
				end else begin
					active_q <= active_c;
					cause_q  <= cause_c;
					if (run) begin
						cycle_start_q <= cs_next;
						phase_start_q <= ps_next;
						beeps_q       <= beeps_next;
						buzzer_q      <= buzzer_next;
						if (burst_start) begin
							burst_len_q <= blen_c;
						end
					end else begin
						beeps_q  <= 2'd0;
						buzzer_q <= 1'b0;
					end
					m_tdata <= {2'b00, cause_c.soil, cause_c.battery, cause_c.water,
						active_c ^ active_q, active_c, run && buzzer_next};
				end
			end
		end
	end

endmodule

// ===== rtl/core/pab_checker.sv =====
// Port-level checker for the priority alarm beeper, bound to the top level
`include "assert_macros.svh"

module pab_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [pab_pkg::OUT_TDATA_W-1:0] m_tdata
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`ASSERT_ALWAYS(a_alarm_is_or, clk, arst_n, !m_tvalid || (m_tdata[1] == (m_tdata[3] || m_tdata[4] || m_tdata[5])))
	`ASSERT_ALWAYS(a_buzz_needs_alarm, clk, arst_n, !m_tvalid || !m_tdata[0] || m_tdata[1])
	`ASSERT_ALWAYS(a_pad_zero, clk, arst_n, !m_tvalid || (m_tdata[7:6] == 2'b00))
	`ASSERT_ALWAYS(a_ready_when_empty, clk, arst_n, m_tvalid || s_tready)

endmodule

bind priority_alarm_beeper pab_checker u_pab_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
